### sv/dle_framed_gps_report_deframer_defines.svh
// Assertion macros shared by the DLE framed report deframer RTL.
// Every macro assumes a clock named i_clk and an active-low reset named i_rst_n.
`ifndef DLE_FRAMED_GPS_REPORT_DEFRAMER_DEFINES_SVH
`define DLE_FRAMED_GPS_REPORT_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DGRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/dgrd_pkg.sv
// Package for the DLE framed report deframer: framing constants, frame mode
// type and the report record type. It depends on nothing else.
`default_nettype none

package dgrd_pkg;

    // Framing characters and report ids.
    localparam logic [7:0] CH_DLE      = 8'h10;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] ID_POSITION = 8'h4A;
    localparam logic [7:0] ID_VELOCITY = 8'h56;

    // A report needs the id byte plus this many data bytes.
    localparam int unsigned MIN_DATA_BYTES = 20;
    // A packet that stores this many bytes is dropped.
    localparam int unsigned MAX_PACKET_BYTES = 255;

    localparam int unsigned WORD_W = 32;

    // Report kind codes.
    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_VELOCITY = 1'b1;

    typedef enum logic [1:0] {
        MODE_HUNT       = 2'd0,
        MODE_HUNT_DLE   = 2'd1,
        MODE_PACKET     = 2'd2,
        MODE_PACKET_DLE = 2'd3
    } t_mode;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] latitude;
        logic [WORD_W-1:0] longitude;
        logic [WORD_W-1:0] altitude;
        logic [WORD_W-1:0] vertical_speed;
        logic [WORD_W-1:0] fix_time;
    } t_report;

endpackage

`default_nettype wire

### sv/dgrd_core.sv
// Byte framing state machine, unstuffing, pending data words and the stored
// report record. Depends on dgrd_pkg and the shared assertion macro header.
`default_nettype none

`include "dle_framed_gps_report_deframer_defines.svh"

module dgrd_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_rx_byte,
    output logic                  o_emit,
    output dgrd_pkg::t_report     o_report
);
    import dgrd_pkg::*;

    t_mode             r_mode;
    t_mode             n_mode;
    logic [7:0]        r_count;
    logic [7:0]        n_count;
    logic [7:0]        r_report_id;
    logic [WORD_W-1:0] r_pend [4];
    t_report           r_stored;

    logic       store;
    logic       finish;
    logic [7:0] pos;
    logic [8:0] pos_inc;
    logic [7:0] pos_m1;
    logic [2:0] word_idx;
    logic       in_data;
    logic       slot_ok;
    logic [1:0] slot;
    logic       is_pos;
    logic       is_vel;
    logic       long_enough;

    // Decode what the current byte does in the current mode.
    always_comb begin
        store  = 1'b0;
        finish = 1'b0;
        pos    = r_count;
        case (r_mode)
            MODE_HUNT: begin
                store = 1'b0;
            end
            MODE_HUNT_DLE: begin
                store = (i_rx_byte != CH_DLE) && (i_rx_byte != CH_ETX);
                pos   = '0;
            end
            MODE_PACKET: begin
                store = (i_rx_byte != CH_DLE);
            end
            MODE_PACKET_DLE: begin
                finish = (i_rx_byte == CH_ETX);
                store  = (i_rx_byte != CH_ETX);
            end
            default: begin
                store = 1'b0;
            end
        endcase
    end

    assign pos_inc = {1'b0, pos} + 9'd1;

    // Next frame mode and stored byte count.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (store) begin
            if (pos_inc >= 9'(MAX_PACKET_BYTES)) begin
                n_mode  = MODE_HUNT;
                n_count = '0;
            end else begin
                n_mode  = MODE_PACKET;
                n_count = pos_inc[7:0];
            end
        end else if (finish) begin
            n_mode  = MODE_HUNT;
            n_count = '0;
        end else begin
            case (r_mode)
                MODE_HUNT: begin
                    if (i_rx_byte == CH_DLE) begin
                        n_mode = MODE_HUNT_DLE;
                    end
                end
                MODE_HUNT_DLE: begin
                    n_mode = MODE_HUNT;
                end
                MODE_PACKET: begin
                    n_mode = MODE_PACKET_DLE;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    // Map a data byte position to its pending word; the clock bias word is skipped.
    assign pos_m1   = pos - 8'd1;
    assign word_idx = pos_m1[4:2];
    assign in_data  = (pos != '0) && (pos <= 8'(MIN_DATA_BYTES));
    assign slot_ok  = in_data && ((word_idx <= 3'd2) || (word_idx == 3'd4));
    assign slot     = (word_idx == 3'd4) ? 2'd3 : word_idx[1:0];

    // A finished packet updates the record if it is a known report of full length.
    assign is_pos      = (r_report_id == ID_POSITION);
    assign is_vel      = (r_report_id == ID_VELOCITY);
    assign long_enough = (r_count >= 8'(MIN_DATA_BYTES + 1));
    assign o_emit      = finish && long_enough && (is_pos || is_vel);

    always_comb begin
        o_report      = r_stored;
        o_report.kind = is_vel ? KIND_VELOCITY : KIND_POSITION;
        if (is_pos) begin
            o_report.latitude  = r_pend[0];
            o_report.longitude = r_pend[1];
            o_report.altitude  = r_pend[2];
        end else begin
            o_report.vertical_speed = r_pend[2];
        end
        o_report.fix_time = r_pend[3];
    end

    // Control state and the stored record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HUNT;
            r_count     <= '0;
            r_report_id <= '0;
            r_stored    <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            if (store && (pos == '0)) begin
                r_report_id <= i_rx_byte;
            end
            if (o_emit) begin
                r_stored <= o_report;
            end
        end
    end

    // Pending data words shift in one byte each, big-endian.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (i_step && store && slot_ok && (slot == 2'(i))) begin
                r_pend[i] <= {r_pend[i][WORD_W-9:0], i_rx_byte};
            end
        end
    end

    `DGRD_ASSERT_NOW(a_hunt_count_zero, (r_mode == MODE_HUNT) || (r_mode == MODE_HUNT_DLE), r_count == '0, "byte count not zero while hunting")
    `DGRD_ASSERT_NOW(a_packet_count_set, (r_mode == MODE_PACKET) || (r_mode == MODE_PACKET_DLE), r_count != '0, "byte count zero inside a packet")
    `DGRD_ASSERT_NOW(a_emit_at_etx, o_emit, (r_mode == MODE_PACKET_DLE) && (i_rx_byte == CH_ETX), "report emitted without DLE ETX")

endmodule

`default_nettype wire

### sv/dle_framed_gps_report_deframer.sv
// Top level of the DLE framed report deframer: input byte register, framing
// core and output record register. Depends on dgrd_pkg, dgrd_core and the macro header.
//
// Usage:
// The input channel takes one received serial byte per item on i_rx_byte,
// qualified by i_valid; the block holds it off with o_stall. The output channel
// presents one report record per item on the o_* fields, qualified by o_valid;
// the receiver holds it with i_stall. A record is produced only when a
// position or velocity report of at least twenty data bytes ends at DLE ETX;
// all other bytes produce nothing.
// An accepted byte is held in the input register until the framing core steps on
// it, and a record completed by its ETX byte is registered in the output record
// register and presented on o_valid. Throughput: one byte per cycle while the
// receiver does not stall a waiting record.
// When the receiver stalls a waiting record, the byte in the input register is
// held and o_stall rises until the record is taken.
// Synchronous reset returns the framing to hunting for a start DLE, clears the
// stored record to zero and empties both registers.
`default_nettype none

`include "dle_framed_gps_report_deframer_defines.svh"

module dle_framed_gps_report_deframer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [7:0]                   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_report_kind,
    output logic [dgrd_pkg::WORD_W-1:0]       o_latitude_bits,
    output logic [dgrd_pkg::WORD_W-1:0]       o_longitude_bits,
    output logic [dgrd_pkg::WORD_W-1:0]       o_altitude_bits,
    output logic [dgrd_pkg::WORD_W-1:0]       o_vertical_speed_bits,
    output logic [dgrd_pkg::WORD_W-1:0]       o_fix_time_bits
);
    import dgrd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_report    r_out;

    logic       advance;
    logic       in_accept;
    logic       emit;
    t_report    report;

    // The held byte moves on whenever the output register is free or draining.
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // Input byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    dgrd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_rx_byte (r_in_byte),
        .o_emit    (emit),
        .o_report  (report)
    );

    // Output record register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= report;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_report_kind         = r_out.kind;
    assign o_latitude_bits       = r_out.latitude;
    assign o_longitude_bits      = r_out.longitude;
    assign o_altitude_bits       = r_out.altitude;
    assign o_vertical_speed_bits = r_out.vertical_speed;
    assign o_fix_time_bits       = r_out.fix_time;

    `DGRD_ASSERT_NOW(a_stall_needs_byte, o_stall, r_in_valid, "input stalled with no byte held")
    `DGRD_ASSERT_NOW(a_no_overwrite, r_out_valid && i_stall, !advance, "record overwritten")
    `DGRD_ASSERT_NEXT(a_emit_shows, advance && emit, o_valid, "emitted record not presented")

endmodule

`default_nettype wire

### tb/dle_framed_gps_report_deframer_tb.sv
// Self-checking testbench for dle_framed_gps_report_deframer: DLE/ETX framed byte
// streams in, report records out, checked against an in-bench deframing predictor.
// Depends on dgrd_pkg and the RTL of the block only.
`default_nettype none

module dle_framed_gps_report_deframer_tb;

    import dgrd_pkg::*;

    // How a frame is introduced on the line before its start DLE.
    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_DLE_DLE,
        LEAD_DLE_ETX,
        LEAD_NOISE
    } t_lead;

    // How the data bytes of a frame are chosen.
    typedef enum logic [1:0] {
        FILL_CONST,
        FILL_RAMP,
        FILL_RAND
    } t_fill;

    typedef struct {
        t_lead       lead;
        logic [7:0]  id;
        int          n_data;
        t_fill       fill;
        logic [7:0]  fill_val;
        int          esc_pct;
        bit          typed;
        t_report     typed_rec;
    } t_frame_row;

    localparam int N_DIRECTED   = 18;
    localparam int PHASE_BYTES  = 145;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_SHOWN    = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [7:0]          i_rx_byte = 8'h00;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_report_kind;
    logic [WORD_W-1:0]   o_latitude_bits;
    logic [WORD_W-1:0]   o_longitude_bits;
    logic [WORD_W-1:0]   o_altitude_bits;
    logic [WORD_W-1:0]   o_vertical_speed_bits;
    logic [WORD_W-1:0]   o_fix_time_bits;

    // Predictor state: framing mode, stored byte count, id, words being
    // collected and the record as last emitted.
    t_mode               rx_mode;
    logic [7:0]          rx_len;
    logic [7:0]          rx_id;
    logic [WORD_W-1:0]   rx_words [4];
    t_report             held_report;

    t_report             pending_reports [$];
    t_frame_row          directed_rows [N_DIRECTED];

    bit                  typed_pending = 1'b0;
    t_report             typed_report;
    int                  bytes_sent = 0;
    int                  mismatches = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    bit                  hold_request = 1'b0;
    int                  hold_left = 0;

    dle_framed_gps_report_deframer u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_rx_byte             (i_rx_byte),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_report_kind         (o_report_kind),
        .o_latitude_bits       (o_latitude_bits),
        .o_longitude_bits      (o_longitude_bits),
        .o_altitude_bits       (o_altitude_bits),
        .o_vertical_speed_bits (o_vertical_speed_bits),
        .o_fix_time_bits       (o_fix_time_bits)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_report mk_report(input logic kind, input logic [31:0] lat,
                                          input logic [31:0] lon, input logic [31:0] alt,
                                          input logic [31:0] vs, input logic [31:0] fix);
        t_report r;
        r.kind           = kind;
        r.latitude       = lat;
        r.longitude      = lon;
        r.altitude       = alt;
        r.vertical_speed = vs;
        r.fix_time       = fix;
        return r;
    endfunction

    // Store one unstuffed packet byte: the id first, then the data bytes of
    // words 0, 1, 2 and 4; word 3 and bytes past the twentieth are not kept.
    function automatic void collect_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned word;
        pos = rx_len;
        if (pos == 0) begin
            rx_id = b;
        end else if (pos <= MIN_DATA_BYTES) begin
            word = (pos - 1) >> 2;
            if (word <= 2) begin
                rx_words[word] = {rx_words[word][23:0], b};
            end else if (word == 4) begin
                rx_words[3] = {rx_words[3][23:0], b};
            end
        end
        // A packet that reaches the maximum length is dropped at once.
        if (pos + 1 >= MAX_PACKET_BYTES) begin
            rx_mode = MODE_HUNT;
            rx_len  = 8'd0;
        end else begin
            rx_mode = MODE_PACKET;
            rx_len  = 8'(pos + 1);
        end
    endfunction

    // Close a packet at DLE ETX; returns 1 when a report updates the record.
    function automatic bit close_packet(output t_report rec);
        int unsigned len;
        len     = rx_len;
        rx_mode = MODE_HUNT;
        rx_len  = 8'd0;
        rec     = held_report;
        if (len < MIN_DATA_BYTES + 1) return 1'b0;
        if (rx_id == ID_POSITION) begin
            held_report.kind      = KIND_POSITION;
            held_report.latitude  = rx_words[0];
            held_report.longitude = rx_words[1];
            held_report.altitude  = rx_words[2];
            held_report.fix_time  = rx_words[3];
        end else if (rx_id == ID_VELOCITY) begin
            held_report.kind           = KIND_VELOCITY;
            held_report.vertical_speed = rx_words[2];
            held_report.fix_time       = rx_words[3];
        end else begin
            return 1'b0;
        end
        rec = held_report;
        return 1'b1;
    endfunction

    // Predict the effect of one received byte on the deframer.
    function automatic bit deframe_byte(input logic [7:0] b, output t_report rec);
        rec = held_report;
        case (rx_mode)
            MODE_HUNT: begin
                if (b == CH_DLE) rx_mode = MODE_HUNT_DLE;
            end
            MODE_HUNT_DLE: begin
                if (b == CH_DLE || b == CH_ETX) begin
                    rx_mode = MODE_HUNT;
                end else begin
                    rx_len = 8'd0;
                    collect_byte(b);
                end
            end
            MODE_PACKET: begin
                if (b == CH_DLE) rx_mode = MODE_PACKET_DLE;
                else collect_byte(b);
            end
            default: begin
                if (b == CH_ETX) return close_packet(rec);
                collect_byte(b);
            end
        endcase
        return 1'b0;
    endfunction

    // Offer one byte, with random idle cycles ahead of it, and wait until
    // the block takes it.
    task automatic send_byte(input logic [7:0] b);
        t_report rec;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (deframe_byte(b, rec)) begin
            if (typed_pending) begin
                pending_reports.push_back(typed_report);
                typed_pending = 1'b0;
            end else begin
                pending_reports.push_back(rec);
            end
        end
    endtask

    // Build one frame on the line: lead-in, start DLE, id, stuffed data and,
    // when asked, the closing DLE ETX.
    task automatic send_frame(input t_lead lead, input logic [7:0] id, input int n_data,
                              input t_fill fill, input logic [7:0] fill_val,
                              input int esc_pct, input bit close);
        logic [7:0] line_bytes [$];
        logic [7:0] d;
        int         n_noise;
        int         i;
        case (lead)
            LEAD_DLE_DLE: begin
                line_bytes.push_back(CH_DLE);
                line_bytes.push_back(CH_DLE);
            end
            LEAD_DLE_ETX: begin
                line_bytes.push_back(CH_DLE);
                line_bytes.push_back(CH_ETX);
            end
            LEAD_NOISE: begin
                n_noise = $urandom_range(1, 8);
                repeat (n_noise) line_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
        line_bytes.push_back(CH_DLE);
        line_bytes.push_back(id);
        for (i = 0; i < n_data; i++) begin
            case (fill)
                FILL_CONST: d = fill_val;
                FILL_RAMP:  d = fill_val + 8'(i);
                default: begin
                    case ($urandom_range(15))
                        0, 1:    d = CH_DLE;
                        2:       d = CH_ETX;
                        default: d = 8'($urandom);
                    endcase
                end
            endcase
            // DLE data is doubled; other bytes may carry a needless escape.
            if (d == CH_DLE) begin
                line_bytes.push_back(CH_DLE);
                line_bytes.push_back(CH_DLE);
            end else if (d != CH_ETX && $urandom_range(99) < esc_pct) begin
                line_bytes.push_back(CH_DLE);
                line_bytes.push_back(d);
            end else begin
                line_bytes.push_back(d);
            end
        end
        if (close) begin
            line_bytes.push_back(CH_DLE);
            line_bytes.push_back(CH_ETX);
        end
        foreach (line_bytes[k]) send_byte(line_bytes[k]);
    endtask

    // One random frame: mostly well-formed reports, then other ids, short
    // and unterminated packets, raw noise and the odd over-long packet.
    task automatic random_frame();
        int          pick;
        int          n;
        logic [7:0]  id;
        t_lead       lead;
        pick = $urandom_range(99);
        id   = $urandom_range(1) ? ID_POSITION : ID_VELOCITY;
        lead = ($urandom_range(9) == 0) ? LEAD_NOISE : LEAD_NONE;
        if (pick < 72) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(27, 80) : $urandom_range(20, 26);
            send_frame(lead, id, n, FILL_RAND, 8'h00, $urandom_range(0, 30), 1'b1);
        end else if (pick < 82) begin
            send_frame(lead, 8'($urandom), $urandom_range(0, 30), FILL_RAND, 8'h00, 10, 1'b1);
        end else if (pick < 88) begin
            send_frame(lead, id, $urandom_range(0, 19), FILL_RAND, 8'h00, 10, 1'b1);
        end else if (pick < 93) begin
            send_frame(lead, id, $urandom_range(20, 24), FILL_RAND, 8'h00, 10, 1'b0);
        end else if (pick < 98) begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom));
        end else begin
            send_frame(LEAD_NONE, id, $urandom_range(240, 270), FILL_RAND, 8'h00, 5, 1'b1);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch on %s: expected %08h, got %08h", name, want, got);
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare every accepted record with the oldest expected one.
    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected record: kind %0d lat %08h", o_report_kind,
                             o_latitude_bits);
            end else begin
                want = pending_reports.pop_front();
                check_field("report_kind", 32'(want.kind), 32'(o_report_kind));
                check_field("latitude_bits", want.latitude, o_latitude_bits);
                check_field("longitude_bits", want.longitude, o_longitude_bits);
                check_field("altitude_bits", want.altitude, o_altitude_bits);
                check_field("vertical_speed_bits", want.vertical_speed,
                            o_vertical_speed_bits);
                check_field("fix_time_bits", want.fix_time, o_fix_time_bits);
            end
        end
    end

    // Stimulus: reset, directed frames, then four random phases.
    initial begin
        int         start;
        bit         pressure_done;
        t_frame_row row;
        directed_rows = '{
            '{LEAD_NONE, ID_POSITION, 20, FILL_CONST, 8'hFF, 0, 1'b1,
              mk_report(KIND_POSITION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h0000_0000, 32'hFFFF_FFFF)},
            '{LEAD_NONE, ID_VELOCITY, 20, FILL_CONST, 8'h00, 0, 1'b1,
              mk_report(KIND_VELOCITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h0000_0000, 32'h0000_0000)},
            // Every data byte is a doubled DLE.
            '{LEAD_NONE, ID_VELOCITY, 20, FILL_CONST, CH_DLE, 0, 1'b1,
              mk_report(KIND_VELOCITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h1010_1010, 32'h1010_1010)},
            // A bare ETX inside a packet is plain data.
            '{LEAD_NONE, ID_POSITION, 20, FILL_CONST, CH_ETX, 0, 1'b1,
              mk_report(KIND_POSITION, 32'h0303_0303, 32'h0303_0303, 32'h0303_0303,
                        32'h1010_1010, 32'h0303_0303)},
            // One data byte short: no update.
            '{LEAD_NONE, ID_POSITION, 19, FILL_CONST, 8'hAA, 0, 1'b0, '0},
            '{LEAD_NONE, 8'h00, 20, FILL_CONST, 8'h55, 0, 1'b0, '0},
            // Start DLE followed by DLE or ETX is dropped before the frame.
            '{LEAD_DLE_DLE, ID_POSITION, 20, FILL_RAND, 8'h00, 0, 1'b0, '0},
            '{LEAD_DLE_ETX, ID_VELOCITY, 20, FILL_RAND, 8'h00, 0, 1'b0, '0},
            // Every data byte escaped by a DLE it does not need.
            '{LEAD_NONE, ID_POSITION, 24, FILL_RAMP, 8'h40, 100, 1'b0, '0},
            '{LEAD_NONE, ID_POSITION, 0, FILL_CONST, 8'h00, 0, 1'b0, '0},
            '{LEAD_NONE, CH_DLE, 20, FILL_RAMP, 8'h60, 0, 1'b0, '0},
            '{LEAD_NONE, CH_ETX, 20, FILL_RAMP, 8'h70, 0, 1'b0, '0},
            '{LEAD_NONE, ID_VELOCITY, 40, FILL_RAMP, 8'h80, 0, 1'b0, '0},
            // Longest packet that still completes, then the first that is dropped.
            '{LEAD_NONE, ID_POSITION, MAX_PACKET_BYTES - 2, FILL_RAMP, 8'h20, 0, 1'b0, '0},
            '{LEAD_NONE, ID_POSITION, MAX_PACKET_BYTES - 1, FILL_RAMP, 8'hC0, 0, 1'b0, '0},
            '{LEAD_NONE, ID_VELOCITY, 300, FILL_RAND, 8'h00, 10, 1'b0, '0},
            '{LEAD_NOISE, 8'hFF, 25, FILL_RAND, 8'h00, 10, 1'b0, '0},
            '{LEAD_NONE, ID_VELOCITY, 20, FILL_RAND, 8'h00, 50, 1'b0, '0}
        };

        rx_mode     = MODE_HUNT;
        rx_len      = 8'd0;
        rx_id       = 8'd0;
        rx_words    = '{default: '0};
        held_report = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames, checked against typed records where they are set.
        foreach (directed_rows[r]) begin
            row           = directed_rows[r];
            typed_pending = row.typed;
            typed_report  = row.typed_rec;
            send_frame(row.lead, row.id, row.n_data, row.fill, row.fill_val, row.esc_pct, 1'b1);
        end

        // Random frames under four idle settings; the first also holds the
        // receiver off long enough that the input backs up.
        pressure_done = 1'b0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_idle_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_idle_pct = 60; end
                default: begin send_idle_pct = 23; recv_idle_pct = 23; end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if (!pressure_done && bytes_sent - start > 40) begin
                    hold_request  = 1'b1;
                    pressure_done = 1'b1;
                end
                random_frame();
            end
        end
        i_valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
